@@ hdl/bvff_pkg.sv @@
package bvff_pkg;

  // Vector geometry
  localparam int VECTOR_BITS = 1024;
  localparam int WORD_BITS   = 64;
  localparam int WORD_COUNT  = VECTOR_BITS / WORD_BITS;
  localparam int WADDR_W     = $clog2(WORD_COUNT);
  localparam int BSEL_W      = $clog2(WORD_BITS);

  // Field widths
  localparam int MODE_W  = 3;
  localparam int INDEX_W = 10;
  localparam int SIZE_W  = 11;

  // Largest legal size
  localparam logic [SIZE_W-1:0] VEC_SIZE_MAX = SIZE_W'(VECTOR_BITS);

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESIZE = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] bit_pos;
    logic               write_value;
    logic [SIZE_W-1:0]  new_size;
  } bvff_in_t;

  typedef struct packed {
    logic               bit_value;
    logic               true_found;
    logic [INDEX_W-1:0] lowest_set;
    logic               false_found;
    logic [INDEX_W-1:0] lowest_clear;
    logic               index_error;
  } bvff_out_t;

endpackage

@@ hdl/bvff_ram.sv @@
module bvff_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bit_vector_find_first.sv @@
// An input transfer starts a sweep, then the drain and finish states; the result is loaded
//   into the output register once it is free. A sweep reads the 16 words of the bit store
//   through a single read port, one word per cycle; no new item is taken before the result is loaded.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_n low, synchronous) empties the vector and clears the control state;
//   the bit store itself is not cleared and needs no clearing pass.
module bit_vector_find_first import bvff_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bvff_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output bvff_out_t out_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_COUNT - 1);

  // Lowest set bit of a word
  function automatic logic [BSEL_W-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
    logic [BSEL_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BSEL_W'(i);
      end
    end
    return pos;
  endfunction

  // Bits of word w whose position lies below lim
  function automatic logic [WORD_BITS-1:0] below_mask(input logic [WADDR_W-1:0] w,
                                                      input logic [SIZE_W-1:0]  lim);
    logic [WORD_BITS-1:0] m;
    logic [SIZE_W-1:0]    pos;
    m = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pos  = SIZE_W'({w, BSEL_W'(i)});
      m[i] = (pos < lim);
    end
    return m;
  endfunction

  logic [1:0]         state_r, state_nxt;
  logic [WADDR_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic               pipe_vld_r, pipe_vld_nxt;
  logic [WADDR_W-1:0] pipe_word_r, pipe_word_nxt;
  bvff_in_t           op_r, op_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [SIZE_W-1:0]  old_size_r, old_size_nxt;
  logic               ierr_r, ierr_nxt;
  logic               tf_r, tf_nxt;
  logic [INDEX_W-1:0] ft_r, ft_nxt;
  logic               fz_r, fz_nxt;
  logic [INDEX_W-1:0] ff_r, ff_nxt;
  logic               bit_r, bit_nxt;
  logic               out_valid_r, out_valid_nxt;
  bvff_out_t          out_r, out_nxt;

  logic                 in_xfer;
  logic                 out_free;
  logic                 ram_we;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] scan_mask;
  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] zeros;
  logic [WADDR_W-1:0]   idx_word;
  logic [BSEL_W-1:0]    idx_bit;
  logic                 idx_hit;
  logic                 idx_in_range;
  logic [SIZE_W-1:0]    sat_size;

  bvff_ram #(
    .DATA_W (WORD_BITS),
    .DEPTH  (WORD_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pipe_word_r),
    .wdata (new_word),
    .re    (ram_re),
    .raddr (rd_cnt_r),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ram_re       = (state_r == ST_SWEEP);
  assign idx_word     = op_r.bit_pos[BSEL_W +: WADDR_W];
  assign idx_bit      = op_r.bit_pos[BSEL_W-1:0];
  assign idx_hit      = (pipe_word_r == idx_word);
  assign idx_in_range = ({1'b0, op_r.bit_pos} < size_r);
  assign sat_size     = (in_data.new_size > VEC_SIZE_MAX) ? VEC_SIZE_MAX : in_data.new_size;

  // Modify stage: word read last cycle is updated and written back in place
  always_comb begin
    new_word = ram_rdata;
    ram_we   = 1'b0;
    unique case (op_r.mode)
      MODE_WRITE: begin
        if (pipe_vld_r && idx_hit && idx_in_range) begin
          new_word[idx_bit] = op_r.write_value;
          ram_we            = 1'b1;
        end
      end
      MODE_CLEAR: begin
        new_word = '0;
        ram_we   = pipe_vld_r;
      end
      MODE_SET: begin
        new_word = '1;
        ram_we   = pipe_vld_r;
      end
      MODE_RESIZE: begin
        // growth clears everything at or above the old size
        if (size_r > old_size_r) begin
          new_word = ram_rdata & below_mask(pipe_word_r, old_size_r);
          ram_we   = pipe_vld_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Scan candidates within the current size
  assign scan_mask = below_mask(pipe_word_r, size_r);
  assign ones      = new_word & scan_mask;
  assign zeros     = ~new_word & scan_mask;

  // Sequencer and accumulators
  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    pipe_vld_nxt  = ram_re;
    pipe_word_nxt = rd_cnt_r;
    op_nxt        = op_r;
    size_nxt      = size_r;
    old_size_nxt  = old_size_r;
    ierr_nxt      = ierr_r;
    tf_nxt        = tf_r;
    ft_nxt        = ft_r;
    fz_nxt        = fz_r;
    ff_nxt        = ff_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    // fold in the word leaving the modify stage
    if (pipe_vld_r) begin
      if (!tf_r && (ones != '0)) begin
        tf_nxt = 1'b1;
        ft_nxt = {pipe_word_r, lowest_one(ones)};
      end
      if (!fz_r && (zeros != '0)) begin
        fz_nxt = 1'b1;
        ff_nxt = {pipe_word_r, lowest_one(zeros)};
      end
      if (idx_hit) begin
        bit_nxt = new_word[idx_bit] && idx_in_range;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt       = in_data;
          old_size_nxt = size_r;
          if (in_data.mode == MODE_RESIZE) begin
            size_nxt = sat_size;
          end
          ierr_nxt   = ((in_data.mode == MODE_READ) || (in_data.mode == MODE_WRITE)) &&
                       ({1'b0, in_data.bit_pos} >= size_r);
          tf_nxt     = 1'b0;
          ft_nxt     = '0;
          fz_nxt     = 1'b0;
          ff_nxt     = '0;
          bit_nxt    = 1'b0;
          rd_cnt_nxt = '0;
          state_nxt  = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (rd_cnt_r == LAST_WORD) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.bit_value    = bit_r;
          out_nxt.true_found   = tf_r;
          out_nxt.lowest_set   = ft_r;
          out_nxt.false_found  = fz_r;
          out_nxt.lowest_clear = ff_r;
          out_nxt.index_error  = ierr_r;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pipe_vld_r  <= 1'b0;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_cnt_r    <= rd_cnt_nxt;
    pipe_word_r <= pipe_word_nxt;
    op_r        <= op_nxt;
    old_size_r  <= old_size_nxt;
    ierr_r      <= ierr_nxt;
    tf_r        <= tf_nxt;
    ft_r        <= ft_nxt;
    fz_r        <= fz_nxt;
    ff_r        <= ff_nxt;
    bit_r       <= bit_nxt;
    out_r       <= out_nxt;
  end

  // Write-back never targets the word being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (pipe_word_r != rd_cnt_r))
    else $error("bit store read and write hit the same word");

  a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= VEC_SIZE_MAX)
    else $error("vector size beyond capacity");

  a_found_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.true_found && out_r.false_found) |->
      (out_r.lowest_set != out_r.lowest_clear))
    else $error("first set and first clear positions coincide");

  a_load_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result loaded before the sweep completed");

endmodule

@@ test/bvff_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the bit vector, keeps a shadow copy of the vector
// and checks every result transfer against the oldest prediction.
module bvff_checker import bvff_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  bvff_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  bvff_out_t out_data,
  output int        errors,
  output int        outstanding
);

  // Shadow of the vector contents and its current length
  logic [VECTOR_BITS-1:0] shadow_bits;
  logic [SIZE_W-1:0]      shadow_size;

  // Predicted results, oldest first
  bvff_out_t expected_q[$];

  // Apply one operation to the shadow vector and return the result it must produce
  function automatic bvff_out_t apply_op(bvff_in_t op);
    bvff_out_t         res;
    logic [SIZE_W-1:0] target;
    logic              hit;
    res = '0;
    hit = {1'b0, op.bit_pos} < shadow_size;
    case (op.mode)
      MODE_READ: begin
        res.index_error = !hit;
      end
      MODE_WRITE: begin
        if (hit) begin
          shadow_bits[op.bit_pos] = op.write_value;
        end else begin
          res.index_error = 1'b1;
        end
      end
      MODE_CLEAR: begin
        shadow_bits = '0;
      end
      MODE_SET: begin
        shadow_bits = '1;
      end
      MODE_RESIZE: begin
        // saturate at capacity; bits exposed by growth come back cleared
        target = (op.new_size > VEC_SIZE_MAX) ? VEC_SIZE_MAX : op.new_size;
        for (int i = int'(shadow_size); i < int'(target); i++) begin
          shadow_bits[i] = 1'b0;
        end
        shadow_size = target;
      end
      default: begin
        // spare codes leave the vector alone
      end
    endcase

    hit = {1'b0, op.bit_pos} < shadow_size;
    res.bit_value = hit ? shadow_bits[op.bit_pos] : 1'b0;

    // lowest set and lowest clear position below the size
    for (int i = 0; i < int'(shadow_size); i++) begin
      if (shadow_bits[i] && !res.true_found) begin
        res.true_found = 1'b1;
        res.lowest_set = INDEX_W'(i);
      end
      if (!shadow_bits[i] && !res.false_found) begin
        res.false_found  = 1'b1;
        res.lowest_clear = INDEX_W'(i);
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    bvff_out_t want;
    if (!rst_n) begin
      shadow_bits = '0;
      shadow_size = '0;
      errors      = 0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(apply_op(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing pending: %p", out_data);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("bit_value", 32'(want.bit_value), 32'(out_data.bit_value));
          check_field("true_found", 32'(want.true_found), 32'(out_data.true_found));
          check_field("lowest_set", 32'(want.lowest_set), 32'(out_data.lowest_set));
          check_field("false_found", 32'(want.false_found), 32'(out_data.false_found));
          check_field("lowest_clear", 32'(want.lowest_clear),
                      32'(out_data.lowest_clear));
          check_field("index_error", 32'(want.index_error), 32'(out_data.index_error));
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

@@ test/tb_bit_vector_find_first.sv @@
`timescale 1ns / 1ps

module tb_bit_vector_find_first;
  import bvff_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int ITEM_TARGET   = 1550;
  localparam int CALM_TAIL     = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_AT_CYCLE = 6000;
  localparam int HOLD_CYCLES   = 250;

  // codes 5 to 7 are unused by the block
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_RESIZE + 3'd1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  bvff_in_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  bvff_out_t out_data;

  int mismatches;
  int outstanding;
  int sent           = 0;
  int cycle_count    = 0;
  int cur_size       = 0;
  bit calm           = 1'b0;
  bit long_hold_done = 1'b0;

  bit_vector_find_first dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  bvff_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .errors      (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic bvff_in_t make_op(logic [MODE_W-1:0] m, int idx, bit v, int sz);
    bvff_in_t op;
    op.mode        = m;
    op.bit_pos     = INDEX_W'(idx);
    op.write_value = v;
    op.new_size    = SIZE_W'(sz);
    return op;
  endfunction

  // Mostly in range once the vector has bits, otherwise anywhere
  function automatic int pick_index();
    if (cur_size > 0 && $urandom_range(0, 9) < 8) begin
      return $urandom_range(0, cur_size - 1);
    end
    return $urandom_range(0, 1023);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return VECTOR_BITS;
    if (r < 14) return $urandom_range(0, VECTOR_BITS);
    if (r < 16) return $urandom_range(VECTOR_BITS + 1, 2047);
    if (r < 19) return $urandom_range(1, 16);
    return 0;
  endfunction

  function automatic bvff_in_t random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return make_op(MODE_READ, pick_index(), 1'($urandom_range(0, 1)),
                               $urandom_range(0, 2047));
    if (r < 70) return make_op(MODE_WRITE, pick_index(), 1'($urandom_range(0, 1)),
                               $urandom_range(0, 2047));
    if (r < 77) return make_op(MODE_CLEAR, $urandom_range(0, 1023),
                               1'($urandom_range(0, 1)), $urandom_range(0, 2047));
    if (r < 84) return make_op(MODE_SET, $urandom_range(0, 1023),
                               1'($urandom_range(0, 1)), $urandom_range(0, 2047));
    if (r < 94) return make_op(MODE_RESIZE, $urandom_range(0, 1023),
                               1'($urandom_range(0, 1)), pick_size());
    return make_op(MODE_SPARE_FIRST + MODE_W'($urandom_range(0, 2)), pick_index(),
                   1'($urandom_range(0, 1)), $urandom_range(0, 2047));
  endfunction

  // One input transfer, with an optional gap in front of it
  task automatic send(bvff_in_t op);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_data  <= op;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (op.mode == MODE_RESIZE) begin
      cur_size = (op.new_size > VEC_SIZE_MAX) ? VECTOR_BITS : int'(op.new_size);
    end
    sent++;
  endtask

  // Stop offering until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: random stall bursts, one long hold-off, calm at the end
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6))
        @(posedge clk);
      if (!long_hold_done && cycle_count >= HOLD_AT_CYCLE) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int  kind;
    bit  fill_val;
    bit  mid_drained;
    mid_drained = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty vector: every read and write is out of range, fills touch hidden bits
    send(make_op(MODE_READ, 0, 1'b0, 0));
    send(make_op(MODE_WRITE, 5, 1'b1, 0));
    send(make_op(MODE_CLEAR, 0, 1'b0, 0));
    send(make_op(MODE_SET, 0, 1'b0, 0));
    send(make_op(MODE_RESIZE, 0, 1'b0, 0));
    // oversize resize saturates; growth clears the exposed bits
    send(make_op(MODE_RESIZE, 0, 1'b0, 2047));
    send(make_op(MODE_READ, 1023, 1'b0, 0));
    send(make_op(MODE_WRITE, 1023, 1'b1, 0));
    send(make_op(MODE_WRITE, 0, 1'b1, 0));
    send(make_op(MODE_READ, 0, 1'b0, 0));
    send(make_op(MODE_WRITE, 0, 1'b0, 0));
    // all ones: no clear bit left, then clear ones at the top and the middle
    send(make_op(MODE_SET, 1023, 1'b0, 0));
    send(make_op(MODE_WRITE, 1023, 1'b0, 0));
    send(make_op(MODE_WRITE, 512, 1'b0, 0));
    // shrink hides bits, out of range access, grow back exposes cleared bits
    send(make_op(MODE_RESIZE, 1023, 1'b0, 8));
    send(make_op(MODE_READ, 1023, 1'b0, 0));
    send(make_op(MODE_WRITE, 8, 1'b1, 0));
    send(make_op(MODE_READ, 7, 1'b0, 0));
    send(make_op(MODE_RESIZE, 7, 1'b0, 1024));
    // spare codes act as a read without an index error
    send(make_op(MODE_SPARE_FIRST, 3, 1'b1, 0));
    send(make_op(MODE_SPARE_FIRST + 3'd1, 1023, 1'b0, 2047));
    send(make_op(MODE_SPARE_FIRST + 3'd2, 8, 1'b1, 1));
    // single bit vector, then empty again
    send(make_op(MODE_RESIZE, 0, 1'b0, 1));
    send(make_op(MODE_WRITE, 0, 1'b1, 0));
    send(make_op(MODE_RESIZE, 0, 1'b0, 0));
    send(make_op(MODE_READ, 0, 1'b0, 0));
    drain();

    // random part, built from short sequences
    while (sent < ITEM_TARGET) begin
      calm = (sent >= ITEM_TARGET - CALM_TAIL);
      if (!mid_drained && sent >= ITEM_TARGET / 2) begin
        mid_drained = 1'b1;
        drain();
      end
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        repeat ($urandom_range(6, 12)) send(random_op());
      end else if (kind < 8) begin
        // fill, then punch holes of the other value at scattered positions
        if (cur_size < 8) begin
          send(make_op(MODE_RESIZE, $urandom_range(0, 1023), 1'($urandom_range(0, 1)),
                       $urandom_range(8, VECTOR_BITS)));
        end
        fill_val = 1'($urandom_range(0, 1));
        send(make_op(fill_val ? MODE_SET : MODE_CLEAR, pick_index(),
                     1'($urandom_range(0, 1)), $urandom_range(0, 2047)));
        repeat ($urandom_range(3, 8)) begin
          if ($urandom_range(0, 3) == 0) begin
            send(make_op(MODE_READ, pick_index(), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 2047)));
          end else begin
            send(make_op(MODE_WRITE, pick_index(), !fill_val, $urandom_range(0, 2047)));
          end
        end
      end else if (kind == 8) begin
        send(make_op(MODE_RESIZE, $urandom_range(0, 1023), 1'($urandom_range(0, 1)),
                     pick_size()));
        repeat (4) send(random_op());
      end else begin
        // noise: every field fully random
        repeat ($urandom_range(2, 5)) begin
          send(make_op(MODE_W'($urandom_range(0, 7)), $urandom_range(0, 1023),
                       1'($urandom_range(0, 1)), $urandom_range(0, 2047)));
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
